// ===== hdl/smd_pkg.sv =====
`timescale 1ns / 1ps

package smd_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [5:0] POS_LAST     = 6'd63;
    localparam logic [5:0] POS_LEN      = 6'd56;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;

    typedef logic [31:0] t_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_PAD,
        S_LEN,
        S_OUT
    } t_state;

    // requests from the sequencer to the compression unit
    typedef struct packed {
        logic  load_word;   // shift word into the schedule window
        t_word word;
        logic  start;       // begin 64 rounds on the window
        logic  init;        // chain value back to the initial constants
    } t_cmp_ctl;

    typedef struct packed {
        logic busy;
        logic done;         // chain value updated this cycle
    } t_cmp_stat;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sig0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sig1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word sml_sig0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic t_word sml_sig1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

// ===== hdl/sha256_message_digest_top.sv =====
`timescale 1ns / 1ps
// A byte that does not close a 64-byte block leaves the input ready; one that closes
//   a block holds the input off for the 64 rounds and the chain update.
// End of message: padding bytes, two length words, one or two block compressions,
//   then 8 digest transfers. No bytes are taken while a block is compressed.
// Reset (i_rst_n low, synchronous): idle, empty block, zero length, initial hash.

module sha256_message_digest_top
    import smd_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF   // 32..64, width of the length count
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_message_end,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_digest_last
);

    // Rate: the 64 rounds run one per cycle through the single round unit in
    // smd_compress; the block is not ready while a block is compressed, while
    // pad bytes or length words go in (one per cycle) or the digest is sent.

    t_state                 r_state, n_state;
    t_state                 r_ret,   n_ret;     // where to go after compression
    logic [5:0]             r_pos,   n_pos;     // byte position in current block
    logic [23:0]            r_acc,   n_acc;     // partial big-endian word
    logic [LENGTH_BITS-1:0] r_bitlen, n_bitlen;
    logic                   r_pad_first, n_pad_first;
    logic                   r_len_lo, n_len_lo;
    logic [2:0]             r_word,  n_word;

    t_cmp_ctl  ctl;
    t_cmp_stat stat;
    t_word     chain [8];

    logic [63:0] len_field;
    logic        b_en;      // insert one byte this cycle
    logic [7:0]  b_val;
    logic        blk_full;

    assign len_field = 64'(r_bitlen);
    assign blk_full  = (r_pos == POS_LAST);

    smd_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_stat  (stat),
        .o_chain (chain)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_pos       <= '0;
            r_bitlen    <= '0;
            r_pad_first <= 1'b0;
            r_len_lo    <= 1'b0;
            r_word      <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_pos       <= n_pos;
            r_bitlen    <= n_bitlen;
            r_pad_first <= n_pad_first;
            r_len_lo    <= n_len_lo;
            r_word      <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_bitlen    = r_bitlen;
        n_pad_first = r_pad_first;
        n_len_lo    = r_len_lo;
        n_word      = r_word;
        ctl         = '0;
        b_en        = 1'b0;
        b_val       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_byte_present) begin
                        b_en     = 1'b1;
                        b_val    = i_data_byte;
                        n_bitlen = r_bitlen + LENGTH_BITS'(8);
                        if (blk_full) begin
                            n_state = S_COMP;
                            n_ret   = S_IDLE;
                        end
                    end
                    // a byte in the same item belongs to the message, pad after it
                    if (i_message_end) begin
                        n_pad_first = 1'b1;
                        n_ret       = S_PAD;
                        if (!(i_byte_present && blk_full)) begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                if (r_pad_first || r_pos != POS_LEN) begin
                    b_en        = 1'b1;
                    b_val       = r_pad_first ? PAD_BYTE : 8'h00;
                    n_pad_first = 1'b0;
                    if (blk_full) begin
                        n_state = S_COMP;
                        n_ret   = S_PAD;
                    end
                end else begin
                    n_state  = S_LEN;
                    n_len_lo = 1'b0;
                end
            end
            S_LEN: begin
                // position is word aligned here, accumulator is empty
                ctl.load_word = 1'b1;
                ctl.word      = r_len_lo ? len_field[31:0] : len_field[63:32];
                n_len_lo      = 1'b1;
                if (r_len_lo) begin
                    ctl.start = 1'b1;
                    n_state   = S_COMP;
                    n_ret     = S_OUT;
                end
            end
            S_COMP: begin
                if (stat.done) begin
                    n_state = r_ret;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_word = r_word + 3'd1;
                    if (r_word == WORD_LAST) begin
                        ctl.init = 1'b1;
                        n_state  = S_IDLE;
                        n_pos    = '0;
                        n_bitlen = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // byte packing, shared by message and padding bytes
        if (b_en) begin
            n_acc = {r_acc[15:0], b_val};
            n_pos = r_pos + 6'd1;
            if (r_pos[1:0] == 2'b11) begin
                ctl.load_word = 1'b1;
                ctl.word      = {r_acc, b_val};
            end
            if (blk_full) begin
                ctl.start = 1'b1;
            end
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = chain[r_word];
    assign o_word_number = r_word;
    assign o_digest_last = (r_word == WORD_LAST);

endmodule

// ===== hdl/smd_compress.sv =====
`timescale 1ns / 1ps

// One SHA-256 round per cycle on a shared adder set, schedule in a 16-word window.
module smd_compress
    import smd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmp_ctl  i_ctl,
    output t_cmp_stat o_stat,
    output t_word     o_chain [8]
);

    t_word      r_win   [16];   // r_win[0] is w[t] during round t
    t_word      r_v     [8];
    t_word      r_chain [8];
    logic       r_busy;
    logic       r_add;
    logic [5:0] r_round;

    t_word n_w;
    t_word t1;
    t_word t2;
    t_word chs;
    t_word mj;

    always_comb begin
        n_w = r_win[0] + sml_sig0(r_win[1]) + r_win[9] + sml_sig1(r_win[14]);
        chs = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1  = r_v[7] + big_sig1(r_v[4]) + chs + ROUND_K[r_round] + r_win[0];
        t2  = big_sig0(r_v[0]) + mj;
    end

    // schedule window: loaded with message words, then self-extending
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_word || r_busy) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= i_ctl.load_word ? i_ctl.word : n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_v <= r_chain;
        end else if (r_busy) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= INIT_HASH;
        end else if (r_add) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_v[i];
            end
        end else if (i_ctl.init) begin
            r_chain <= INIT_HASH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_add   <= 1'b0;
            r_round <= '0;
        end else begin
            r_add <= 1'b0;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == ROUND_LAST) begin
                    r_busy <= 1'b0;
                    r_add  <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy | r_add;
    assign o_stat.done = r_add;
    assign o_chain     = r_chain;

endmodule

// ===== hdl/smd_checker.sv =====
`timescale 1ns / 1ps

module smd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_number,
    input logic        o_digest_last
);

    // held result must not change while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_word)
                                && $stable(o_word_number))
        else $error("digest word changed while stalled");

    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_digest_last |=>
            o_valid && o_word_number == $past(o_word_number) + 3'd1)
        else $error("digest words out of sequence");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digest_last == (o_word_number == 3'd7)))
        else $error("last flag not on word seven");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input taken while digest pending");

    a_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_digest_last |=> !o_valid && o_ready)
        else $error("no return to idle after last digest word");

endmodule

bind sha256_message_digest_top smd_checker u_smd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_digest_word (o_digest_word),
    .o_word_number (o_word_number),
    .o_digest_last (o_digest_last)
);
